>>> hdl/pbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbs_pkg;

   // Request action codes.
   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_CHANGE  = 3'd1,
      ACT_PULSE   = 3'd2,
      ACT_PWRON   = 3'd3,
      ACT_RELEASE = 3'd4
   } action_type;

   // Register indexes on the configuration port (byte address is 4 times the index).
   typedef enum logic [2:0] {
      REG_PULSE_EN   = 3'd0,
      REG_CHARGER_EN = 3'd1,
      REG_RAIL_WAIT  = 3'd2,
      REG_T0         = 3'd3,
      REG_T1         = 3'd4,
      REG_LID_PULSE  = 3'd5
   } reg_index_type;

   localparam int unsigned ADDR_BITS = 5;

   // Register widths and reset values.
   localparam int unsigned RAIL_BITS  = 8;
   localparam int unsigned T0_BITS    = 10;
   localparam int unsigned T1_BITS    = 16;
   localparam int unsigned LID_BITS   = 10;
   localparam int unsigned LOAD_BITS  = 16;

   localparam logic [RAIL_BITS-1:0] RAIL_WAIT_RESET = 8'd5;
   localparam logic [T0_BITS-1:0]   T0_RESET        = 10'd32;
   localparam logic [T1_BITS-1:0]   T1_RESET        = 16'd3968;
   localparam logic [LID_BITS-1:0]  LID_RESET       = 10'd200;

endpackage

`default_nettype wire

>>> hdl/power_button_stretch_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

// Results are registered: each goes into the result register, or into the skid register while one waits.
// Throughput: one request per cycle while the skid register is empty; a two-entry output buffer (result
// register plus skid register) takes one more request while the result side stalls, then holds requests off.
// Reset: synchronous, active high; state goes to idle, the timer to zero, the line
// to released, and all configuration registers to their documented defaults.
module power_button_stretch_fsm #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic        req_button_pressed,
   input  wire logic        req_chipset_off,
   input  wire logic        req_rail_ready,
   input  wire logic        req_battery_blocks,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_pch_line_level,
   output logic             rsp_exit_hard_off,
   output logic [2:0]       rsp_state_code,
   output logic             rsp_change_ignored,
   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [pbs_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PRESSED  = 3'd1,
      ST_T0       = 3'd2,
      ST_T1       = 3'd3,
      ST_HELD     = 3'd4,
      ST_LID      = 3'd5,
      ST_RELEASED = 3'd6,
      ST_EAT      = 3'd7
   } state_type;

   typedef struct packed {
      logic       line;
      logic       strobe;
      state_type  state;
      logic       ignored;
   } result_type;

   localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

   // Load a length into the timer, saturating when the timer is narrower.
   function automatic logic [TIMER_BITS-1:0] timer_load(
      input logic [pbs_pkg::LOAD_BITS-1:0] len
   );
      logic [TIMER_BITS-1:0] val;
      if (32'(len) > TIMER_MAX) begin
         val = TIMER_MAX[TIMER_BITS-1:0];
      end else begin
         val = TIMER_BITS'(len);
      end
      return val;
   endfunction

   // Configuration registers.
   logic                          pulse_en_ff;
   logic                          charger_en_ff;
   logic [pbs_pkg::RAIL_BITS-1:0] rail_wait_ff;
   logic [pbs_pkg::T0_BITS-1:0]   t0_ff;
   logic [pbs_pkg::T1_BITS-1:0]   t1_ff;
   logic [pbs_pkg::LID_BITS-1:0]  lid_ff;

   // Control state.
   state_type               state_ff, state_in;
   logic [TIMER_BITS-1:0]   rem_ff, rem_in;
   logic                    line_ff, line_in;

   // Output buffer.
   logic       out_valid_ff;
   result_type out_ff;
   logic       skid_valid_ff;
   result_type skid_ff;

   logic       accept;
   logic       pop;
   logic       csr_write;
   logic [2:0] csr_index;
   result_type result;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[pbs_pkg::ADDR_BITS-1:2];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_en_ff   <= 1'b1;
         charger_en_ff <= 1'b1;
         rail_wait_ff  <= pbs_pkg::RAIL_WAIT_RESET;
         t0_ff         <= pbs_pkg::T0_RESET;
         t1_ff         <= pbs_pkg::T1_RESET;
         lid_ff        <= pbs_pkg::LID_RESET;
      end else if (csr_write) begin
         case (csr_index)
            pbs_pkg::REG_PULSE_EN:   pulse_en_ff   <= pwdata[0];
            pbs_pkg::REG_CHARGER_EN: charger_en_ff <= pwdata[0];
            pbs_pkg::REG_RAIL_WAIT:  rail_wait_ff  <= pwdata[pbs_pkg::RAIL_BITS-1:0];
            pbs_pkg::REG_T0:         t0_ff         <= pwdata[pbs_pkg::T0_BITS-1:0];
            pbs_pkg::REG_T1:         t1_ff         <= pwdata[pbs_pkg::T1_BITS-1:0];
            pbs_pkg::REG_LID_PULSE:  lid_ff        <= pwdata[pbs_pkg::LID_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (csr_index)
         pbs_pkg::REG_PULSE_EN:   prdata = 32'(pulse_en_ff);
         pbs_pkg::REG_CHARGER_EN: prdata = 32'(charger_en_ff);
         pbs_pkg::REG_RAIL_WAIT:  prdata = 32'(rail_wait_ff);
         pbs_pkg::REG_T0:         prdata = 32'(t0_ff);
         pbs_pkg::REG_T1:         prdata = 32'(t1_ff);
         pbs_pkg::REG_LID_PULSE:  prdata = 32'(lid_ff);
         default:                 prdata = 32'd0;
      endcase
   end

   // Handshakes: the skid register must be free to take a new request.
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   // Next state for one request.
   always_comb begin
      logic                  do_eval;
      state_type             ev_state;
      logic                  strobe;
      logic                  ignored;
      logic                  gated_low;
      logic [TIMER_BITS-1:0] rem_dec;

      state_in  = state_ff;
      rem_in    = rem_ff;
      line_in   = line_ff;
      do_eval   = 1'b0;
      ev_state  = state_ff;
      strobe    = 1'b0;
      ignored   = 1'b0;
      // Asserting the line is suppressed while the chipset is off and the charger blocks.
      gated_low = charger_en_ff && req_chipset_off && req_battery_blocks;
      rem_dec   = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;

      case (req_action)
         pbs_pkg::ACT_TICK: begin
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               do_eval = 1'b1;
            end
         end
         pbs_pkg::ACT_CHANGE: begin
            if (state_ff == ST_LID) begin
               ignored = 1'b1;
            end else if (req_button_pressed) begin
               do_eval  = 1'b1;
               ev_state = ST_PRESSED;
            end else if (state_ff == ST_EAT) begin
               state_in = ST_IDLE;
               rem_in   = '0;
               ignored  = 1'b1;
            end else begin
               do_eval  = 1'b1;
               ev_state = ST_RELEASED;
            end
         end
         pbs_pkg::ACT_PULSE, pbs_pkg::ACT_PWRON: begin
            if (req_action == pbs_pkg::ACT_PULSE || req_chipset_off) begin
               strobe   = 1'b1;
               line_in  = gated_low;
               state_in = ST_LID;
               rem_in   = timer_load(pbs_pkg::LOAD_BITS'(lid_ff));
            end
         end
         pbs_pkg::ACT_RELEASE: begin
            line_in  = 1'b1;
            state_in = req_button_pressed ? ST_EAT : ST_IDLE;
            rem_in   = '0;
         end
         default: ;
      endcase

      // Evaluation of the current state on expiry or on a button change.
      if (do_eval) begin
         rem_in   = '0;
         state_in = ev_state;
         case (ev_state)
            ST_PRESSED: begin
               if (req_chipset_off) begin
                  if (req_rail_ready) begin
                     strobe   = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     rem_in = timer_load(pbs_pkg::LOAD_BITS'(rail_wait_ff));
                  end
               end else if (pulse_en_ff) begin
                  rem_in   = timer_load(pbs_pkg::LOAD_BITS'(t0_ff));
                  state_in = ST_T0;
                  line_in  = gated_low;
               end else begin
                  rem_in   = timer_load(t1_ff);
                  state_in = ST_T1;
               end
            end
            ST_T0: begin
               rem_in   = timer_load(t1_ff);
               state_in = ST_T1;
               line_in  = 1'b1;
            end
            ST_T1: begin
               if (!req_chipset_off) begin
                  line_in = 1'b0;
               end
               state_in = ST_HELD;
            end
            ST_RELEASED, ST_LID: begin
               line_in  = 1'b1;
               state_in = ST_IDLE;
            end
            default: ;
         endcase
      end

      result.line    = line_in;
      result.strobe  = strobe;
      result.state   = state_in;
      result.ignored = ignored;
   end

   // State update on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rem_ff   <= '0;
         line_ff  <= 1'b1;
      end else if (accept) begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
         line_ff  <= line_in;
      end
   end

   // Result register and skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
            out_ff       <= result;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_ff       <= result;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_ff       <= result;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pch_line_level = out_ff.line;
   assign rsp_exit_hard_off  = out_ff.strobe;
   assign rsp_state_code     = out_ff.state;
   assign rsp_change_ignored = out_ff.ignored;

   // The skid register only fills behind a waiting result.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the result register is empty");

   // The exit-hard-off strobe only comes with a finished power-on or a lid pulse.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_exit_hard_off) |->
         (rsp_state_code == ST_IDLE || rsp_state_code == ST_LID))
      else $error("exit-hard-off strobe with an unexpected state");

   // While a release is being eaten the line stays released.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EAT) |-> line_ff)
      else $error("line asserted while eating a release");

   // The timer only runs in timed states.
   assert property (@(posedge clock) disable iff (reset)
      (rem_ff != '0) |->
         (state_ff == ST_PRESSED || state_ff == ST_T0 || state_ff == ST_T1 ||
          state_ff == ST_LID))
      else $error("timer running in an untimed state");

endmodule

`default_nettype wire
